### sv/pcs_pkg.sv
// ============================================================================
// pcs_pkg
// Shared types and constants of the pixel color class segmenter.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package pcs_pkg;

    // Result codes
    typedef enum logic [2:0] {
        CLASS_RED        = 3'd0,
        CLASS_YELLOW     = 3'd1,
        CLASS_GREEN      = 3'd2,
        CLASS_PURPLE     = 3'd3,
        CLASS_BLUE_FLOOR = 3'd4,
        CLASS_OTHER      = 3'd5
    } pixel_class_t;

    // Item commands
    localparam logic CMD_SURVEY   = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    // Register map (word index, byte address = 4 * index)
    localparam int unsigned PADDR_W = 4;
    localparam logic [1:0] REG_PURPLE_MIN  = 2'd0;
    localparam logic [1:0] REG_FLOOR_MAX   = 2'd1;
    localparam logic [1:0] REG_DARK_START  = 2'd2;

    // Widths
    localparam int unsigned DIST_W = 18;
    localparam int unsigned LUM_W  = 16;

    // Reset values
    localparam logic [DIST_W-1:0] PURPLE_MIN_RST = 18'd22500;
    localparam logic [DIST_W-1:0] FLOOR_MAX_RST  = 18'd32400;
    localparam logic [LUM_W-1:0]  DARK_START_RST = 16'd65025;

    // One RGB color
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Classification thresholds
    typedef struct packed {
        logic [DIST_W-1:0] purple_min;
        logic [DIST_W-1:0] floor_max;
    } thresh_t;

endpackage : pcs_pkg

`default_nettype wire

### sv/pcs_classify.sv
// ============================================================================
// pcs_classify
// Combinational color classifier: distance to the black reference and the
// ordered ratio tests. All truncating divisions are folded into
// cross-multiplied compares (floor(x/d) < y  <=>  x < d*y).
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pcs_classify (
    input  wire pcs_pkg::rgb_t    pix,
    input  wire pcs_pkg::rgb_t    ref_color,
    input  wire pcs_pkg::thresh_t thresh,
    output pcs_pkg::pixel_class_t pixel_class
);

    logic [7:0]  d_r, d_g, d_b;
    logic [pcs_pkg::DIST_W-1:0] dist_sq;
    logic [12:0] r13, g13, b13;
    logic [12:0] rg13, gb13, rb13;
    logic is_red, is_yellow, is_green, is_purple, is_blue, is_floor;

    // Absolute differences to the reference
    assign d_r = (pix.red   >= ref_color.red)   ? pix.red   - ref_color.red
                                                : ref_color.red   - pix.red;
    assign d_g = (pix.green >= ref_color.green) ? pix.green - ref_color.green
                                                : ref_color.green - pix.green;
    assign d_b = (pix.blue  >= ref_color.blue)  ? pix.blue  - ref_color.blue
                                                : ref_color.blue  - pix.blue;

    // Squared distance, at most 3*255^2 so 18 bits
    assign dist_sq = {2'd0, 16'(d_r * d_r)} + {2'd0, 16'(d_g * d_g)}
                   + {2'd0, 16'(d_b * d_b)};

    assign r13  = {5'd0, pix.red};
    assign g13  = {5'd0, pix.green};
    assign b13  = {5'd0, pix.blue};
    assign rg13 = r13 + g13;
    assign gb13 = g13 + b13;
    assign rb13 = r13 + b13;

    // Ratio tests
    assign is_red    = (gb13 * 13'd5 < r13 * 13'd8) && (g13 * 13'd14 < r13 * 13'd10);
    assign is_yellow = (b13 * 13'd15 < r13 * 13'd10) && (b13 * 13'd15 < g13 * 13'd10);
    assign is_green  = (rb13 * 13'd5 < g13 * 13'd8);
    assign is_purple = (rg13 * 13'd9 < b13 * 13'd16) && (pix.red > pix.green)
                    && (dist_sq > thresh.purple_min);
    assign is_blue   = (rg13 * 13'd6 < b13 * 13'd8);
    assign is_floor  = (dist_sq < thresh.floor_max);

    // First match wins
    always_comb begin
        if (is_red) begin
            pixel_class = pcs_pkg::CLASS_RED;
        end else if (is_yellow) begin
            pixel_class = pcs_pkg::CLASS_YELLOW;
        end else if (is_green) begin
            pixel_class = pcs_pkg::CLASS_GREEN;
        end else if (is_purple) begin
            pixel_class = pcs_pkg::CLASS_PURPLE;
        end else if (is_blue || is_floor) begin
            pixel_class = pcs_pkg::CLASS_BLUE_FLOOR;
        end else begin
            pixel_class = pcs_pkg::CLASS_OTHER;
        end
    end

endmodule : pcs_classify

`default_nettype wire

### sv/pixel_color_class_segmenter_core.sv
// ============================================================================
// pixel_color_class_segmenter_core
// Two-pass pixel color segmenter: darkest-pixel survey and color classify.
// ============================================================================
// Usage:
//   Input channel s_*: one pixel beat per cycle. s_cmd = 0 is a survey beat;
//   it updates the black reference (darkest r^2+g^2+b^2 so far, restarted by
//   s_frame_start) and produces no result. s_cmd = 1 is a classify beat; it
//   produces exactly one m_pixel_class beat, in order.
//   A classify beat passes the input register and the result register to m_*.
//   One beat per cycle in both passes while the result slot is free, through
//   one input register, one level of compare logic and the result register.
//   A survey beat updates the reference as it leaves the input register, so a
//   classify beat right behind it already sees the new reference.
//   When m_ready is low the result register holds; the input register still
//   takes one more beat, and survey beats keep draining since they need no
//   result slot. s_ready drops only while a classify beat waits for the slot.
//   Reset (aresetn low, synchronous) empties both registers, loads register
//   defaults and sets the reference to black with darkest level 65025.
//   APB port: 0x0 purple_min_dist_sq, 0x4 floor_max_dist_sq, 0x8
//   darkest_start. pready is tied high; write only while idle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pixel_color_class_segmenter_core (
    input  wire         aclk,
    input  wire         aresetn,
    // Pixel input
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_cmd,
    input  wire         s_frame_start,
    input  wire  [7:0]  s_red,
    input  wire  [7:0]  s_green,
    input  wire  [7:0]  s_blue,
    // Class output
    output logic        m_valid,
    input  wire         m_ready,
    output logic [2:0]  m_pixel_class,
    // Configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [pcs_pkg::PADDR_W-1:0] paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers
    logic [pcs_pkg::DIST_W-1:0] purple_min_reg;
    logic [pcs_pkg::DIST_W-1:0] floor_max_reg;
    logic [pcs_pkg::LUM_W-1:0]  dark_start_reg;
    logic                       cfg_wr;
    logic [1:0]                 cfg_idx;

    // Survey state
    logic [pcs_pkg::LUM_W-1:0]  dark_lum_reg, dark_lum_next;
    pcs_pkg::rgb_t              ref_reg, ref_next;

    // Input stage
    logic                       in_valid_reg;
    logic                       in_cmd_reg;
    logic                       in_fs_reg;
    pcs_pkg::rgb_t              in_pix_reg;

    // Result stage
    logic                       out_valid_reg;
    pcs_pkg::pixel_class_t      class_reg;

    logic                       out_free;
    logic                       in_adv;
    logic                       in_take;
    logic                       survey_go;
    logic                       classify_go;
    logic [pcs_pkg::DIST_W-1:0] lum;
    logic [pcs_pkg::LUM_W-1:0]  base_lum;
    pcs_pkg::rgb_t              base_ref;
    pcs_pkg::thresh_t           thresh;
    pcs_pkg::pixel_class_t      class_calc;

    // APB access
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (cfg_idx)
            pcs_pkg::REG_PURPLE_MIN: prdata = {14'd0, purple_min_reg};
            pcs_pkg::REG_FLOOR_MAX:  prdata = {14'd0, floor_max_reg};
            pcs_pkg::REG_DARK_START: prdata = {16'd0, dark_start_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            purple_min_reg <= pcs_pkg::PURPLE_MIN_RST;
            floor_max_reg  <= pcs_pkg::FLOOR_MAX_RST;
            dark_start_reg <= pcs_pkg::DARK_START_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                pcs_pkg::REG_PURPLE_MIN: purple_min_reg <= pwdata[pcs_pkg::DIST_W-1:0];
                pcs_pkg::REG_FLOOR_MAX:  floor_max_reg  <= pwdata[pcs_pkg::DIST_W-1:0];
                pcs_pkg::REG_DARK_START: dark_start_reg <= pwdata[pcs_pkg::LUM_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: survey beats need no result slot
    assign out_free    = !out_valid_reg || m_ready;
    assign in_adv      = in_valid_reg && ((in_cmd_reg == pcs_pkg::CMD_SURVEY) || out_free);
    assign s_ready     = !in_valid_reg || in_adv;
    assign in_take     = s_valid && s_ready;
    assign survey_go   = in_adv && (in_cmd_reg == pcs_pkg::CMD_SURVEY);
    assign classify_go = in_adv && (in_cmd_reg == pcs_pkg::CMD_CLASSIFY);

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_cmd_reg       <= s_cmd;
            in_fs_reg        <= s_frame_start;
            in_pix_reg.red   <= s_red;
            in_pix_reg.green <= s_green;
            in_pix_reg.blue  <= s_blue;
        end
    end

    // Darkest-pixel tracking
    assign lum = {2'd0, 16'(in_pix_reg.red * in_pix_reg.red)}
               + {2'd0, 16'(in_pix_reg.green * in_pix_reg.green)}
               + {2'd0, 16'(in_pix_reg.blue * in_pix_reg.blue)};

    always_comb begin
        base_lum = in_fs_reg ? dark_start_reg : dark_lum_reg;
        base_ref = in_fs_reg ? '0 : ref_reg;
        if (lum < {2'd0, base_lum}) begin
            dark_lum_next = lum[pcs_pkg::LUM_W-1:0];
            ref_next      = in_pix_reg;
        end else begin
            dark_lum_next = base_lum;
            ref_next      = base_ref;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dark_lum_reg <= pcs_pkg::DARK_START_RST;
            ref_reg      <= '0;
        end else if (survey_go) begin
            dark_lum_reg <= dark_lum_next;
            ref_reg      <= ref_next;
        end
    end

    // Classifier
    assign thresh.purple_min = purple_min_reg;
    assign thresh.floor_max  = floor_max_reg;

    pcs_classify u_classify (
        .pix         (in_pix_reg),
        .ref_color   (ref_reg),
        .thresh      (thresh),
        .pixel_class (class_calc)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= classify_go;
        end
    end

    always_ff @(posedge aclk) begin
        if (classify_go) begin
            class_reg <= class_calc;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_pixel_class = class_reg;

endmodule : pixel_color_class_segmenter_core

`default_nettype wire

### sv/pcs_checker.sv
// ============================================================================
// pcs_checker
// Port-level checks of the segmenter core, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pcs_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_valid,
    input wire        s_ready,
    input wire        m_valid,
    input wire        m_ready,
    input wire [2:0]  m_pixel_class
);

    // A stalled result beat holds its class
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_class))
    else $error("stalled result beat changed");

    // Reset empties the result register
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
    else $error("result valid after reset");

    // With the result slot empty the input never blocks
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
    else $error("input stalled with empty result slot");

    // Only defined class codes leave the block
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pixel_class <= pcs_pkg::CLASS_OTHER))
    else $error("undefined class code");

    // No result appears without an accepted beat before it
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2) || $past(s_valid && s_ready, 1)
            || $past(m_valid, 1))
    else $error("result without input beat");

endmodule : pcs_checker

bind pixel_color_class_segmenter_core pcs_checker u_pcs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_pixel_class (m_pixel_class)
);

`default_nettype wire
